/* src/ffud_pkg.sv */
// ----------------------------------------------------------------------------
// ffud_pkg
// Shared types and constants for the form field extractor / percent decoder.
// ----------------------------------------------------------------------------
package ffud_pkg;

	// default cap on encoded value bytes
	localparam int unsigned MAX_ENCODED_LEN_DEF = 255;
	// key register holds this many bytes
	localparam logic [3:0]  KEY_BYTES = 4'd8;

	// configuration register indexes
	localparam logic [1:0] REG_KEY_CHARS  = 2'd0;
	localparam logic [1:0] REG_KEY_LENGTH = 2'd1;
	localparam logic [1:0] REG_OUT_LIMIT  = 2'd2;

	localparam logic [63:0] KEY_CHARS_RST  = 64'd0;
	localparam logic [3:0]  KEY_LENGTH_RST = 4'd4;
	localparam logic [7:0]  OUT_LIMIT_RST  = 8'd64;

	// characters
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// result queue
	localparam int unsigned RES_MAX   = 4;
	localparam int unsigned RES_DEPTH = 8;
	localparam int unsigned RES_AW    = $clog2(RES_DEPTH);
	localparam int unsigned RES_CW    = $clog2(RES_DEPTH + 1);

	typedef struct packed {
		logic [63:0] key_chars;
		logic [3:0]  key_length;
		logic [7:0]  out_limit;
	} cfg_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       found;
		logic       last;
	} result_t;

	// all results caused by one body byte
	typedef struct packed {
		logic [2:0]            count;
		result_t [RES_MAX-1:0] item;
	} res_batch_t;

	typedef enum logic [4:0] {
		PH_MATCH    = 5'b00001,
		PH_AFTER_EQ = 5'b00010,
		PH_SKIP     = 5'b00100,
		PH_VALUE    = 5'b01000,
		PH_DONE     = 5'b10000
	} phase_t;

endpackage

/* src/ffud_cfg.sv */
// ----------------------------------------------------------------------------
// ffud_cfg
// Configuration registers: key bytes, key length and output byte limit.
// ----------------------------------------------------------------------------
module ffud_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [63:0]   cfg_data,
	output ffud_pkg::cfg_t cfg
);
	import ffud_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_chars  <= KEY_CHARS_RST;
			cfg_q.key_length <= KEY_LENGTH_RST;
			cfg_q.out_limit  <= OUT_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_KEY_CHARS:  cfg_q.key_chars  <= cfg_data;
				REG_KEY_LENGTH: cfg_q.key_length <= cfg_data[3:0];
				REG_OUT_LIMIT:  cfg_q.out_limit  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule

/* src/ffud_parser.sv */
// ----------------------------------------------------------------------------
// ffud_parser
// Per-body state and combinational token match / percent decode of one byte.
// Produces the whole batch of results for the accepted byte.
// ----------------------------------------------------------------------------
module ffud_parser #(
	parameter int unsigned MAX_ENCODED_LEN = ffud_pkg::MAX_ENCODED_LEN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          body_byte,
	input  logic                end_of_body,
	input  ffud_pkg::cfg_t      cfg,
	output ffud_pkg::res_batch_t batch
);
	import ffud_pkg::*;

	localparam int unsigned EncW = $clog2(MAX_ENCODED_LEN + 1);

	typedef struct packed {
		logic       emit;
		logic [7:0] eb;
		logic [1:0] pc;
		logic [7:0] px;
	} fb_t;

	// one decode step with no held hex digit
	function automatic fb_t feed_basic(input logic [7:0] v, input logic [1:0] pc,
			input logic [7:0] px);
		fb_t r;
		r.emit = 1'b0;
		r.eb   = v;
		r.pc   = pc;
		r.px   = px;
		if (pc == 2'd1) begin
			r.px = v;
			r.pc = 2'd2;
		end else if (v == CH_PLUS) begin
			r.emit = 1'b1;
			r.eb   = CH_SPACE;
		end else if (v == CH_PCT) begin
			r.pc = 2'd1;
		end else begin
			r.emit = 1'b1;
		end
		return r;
	endfunction

	// {valid, nibble}
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66)
			r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46)
			r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	phase_t          phase_q;
	logic [3:0]      kpos_q;
	logic [EncW-1:0] enc_q;
	logic [7:0]      dec_q;
	logic [7:0]      pbyte_q;
	logic [1:0]      pcnt_q;
	logic            found_q;

	phase_t          ph;
	logic [3:0]      kp;
	logic [EncW-1:0] ec;
	logic [1:0]      pc;
	logic [7:0]      px;
	logic            fnd;
	logic [1:0]      nc;
	logic [7:0]      cand [0:3];
	logic            flush_req;
	logic            val;
	logic [3:0]      klen;
	logic [7:0]      kch;
	logic [4:0]      hi;
	logic [4:0]      lo;
	fb_t             fa;
	fb_t             fb;
	logic [1:0]      ne;
	logic [7:0]      dec_nxt;

	assign klen = (cfg.key_length > KEY_BYTES) ? KEY_BYTES : cfg.key_length;
	assign kch  = cfg.key_chars[{kpos_q[2:0], 3'b000} +: 8];

	always_comb begin
		ph        = phase_q;
		kp        = kpos_q;
		ec        = enc_q;
		pc        = pcnt_q;
		px        = pbyte_q;
		fnd       = found_q;
		nc        = 2'd0;
		cand      = '{default: 8'd0};
		flush_req = 1'b0;
		val       = 1'b0;
		hi        = 5'd0;
		lo        = 5'd0;
		fa        = '0;
		fb        = '0;

		if (body_byte == CH_NUL) begin
			if (phase_q == PH_VALUE)
				flush_req = 1'b1;
			ph = PH_DONE;
		end else begin
			unique case (phase_q)
				PH_MATCH: begin
					if (body_byte == CH_AMP) begin
						kp = 4'd0;
					end else if (kpos_q < klen) begin
						if (body_byte == kch)
							kp = kpos_q + 4'd1;
						else
							ph = PH_SKIP;
					end else if (body_byte == CH_EQ) begin
						ph = PH_AFTER_EQ;
					end else begin
						ph = PH_SKIP;
					end
				end
				PH_AFTER_EQ: begin
					if (body_byte == CH_AMP) begin
						ph = PH_MATCH;
						kp = 4'd0;
					end else begin
						fnd = 1'b1;
						ph  = PH_VALUE;
						val = 1'b1;
					end
				end
				PH_SKIP: begin
					if (body_byte == CH_AMP) begin
						ph = PH_MATCH;
						kp = 4'd0;
					end
				end
				PH_VALUE: val = 1'b1;
				PH_DONE:  ;
				default:  ;
			endcase
		end

		if (val) begin
			if (body_byte == CH_AMP) begin
				flush_req = 1'b1;
				ph        = PH_DONE;
			end else begin
				if (pc == 2'd2) begin
					hi = hex_val(px);
					lo = hex_val(body_byte);
					pc = 2'd0;
					if (hi[4] && lo[4]) begin
						cand[nc] = {hi[3:0], lo[3:0]};
						nc = nc + 2'd1;
					end else begin
						// bad escape: literal '%', then rescan held digit and this byte
						cand[nc] = CH_PCT;
						nc = nc + 2'd1;
						fa = feed_basic(px, pc, px);
						if (fa.emit) begin
							cand[nc] = fa.eb;
							nc = nc + 2'd1;
						end
						pc = fa.pc;
						px = fa.px;
						fb = feed_basic(body_byte, pc, px);
						if (fb.emit) begin
							cand[nc] = fb.eb;
							nc = nc + 2'd1;
						end
						pc = fb.pc;
						px = fb.px;
					end
				end else begin
					fb = feed_basic(body_byte, pc, px);
					if (fb.emit) begin
						cand[nc] = fb.eb;
						nc = nc + 2'd1;
					end
					pc = fb.pc;
					px = fb.px;
				end
				ec = enc_q + EncW'(1);
				if (ec == EncW'(MAX_ENCODED_LEN)) begin
					flush_req = 1'b1;
					ph        = PH_DONE;
				end
			end
		end

		if (end_of_body && ph == PH_VALUE)
			flush_req = 1'b1;

		// open escape at end of value passes through literally, a held '+' as space
		if (flush_req) begin
			if (pc != 2'd0) begin
				cand[nc] = CH_PCT;
				nc = nc + 2'd1;
			end
			if (pc == 2'd2) begin
				cand[nc] = (px == CH_PLUS) ? CH_SPACE : px;
				nc = nc + 2'd1;
			end
			pc = 2'd0;
		end
	end

	// output limit: candidate i goes out only while dec_q + i < out_limit
	always_comb begin
		ne = 2'd0;
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < nc && ({1'b0, dec_q} + 9'(i)) < {1'b0, cfg.out_limit})
				ne = ne + 2'd1;
		end
		dec_nxt = dec_q + {6'd0, ne};
	end

	always_comb begin
		batch.count = {1'b0, ne} + {2'd0, end_of_body};
		for (int i = 0; i < RES_MAX; i++) begin
			if (3'(i) < {1'b0, ne}) begin
				batch.item[i].out_byte   = cand[i];
				batch.item[i].byte_valid = 1'b1;
				batch.item[i].found      = fnd;
				batch.item[i].last       = 1'b0;
			end else begin
				batch.item[i].out_byte   = 8'd0;
				batch.item[i].byte_valid = 1'b0;
				batch.item[i].found      = fnd;
				batch.item[i].last       = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MATCH;
			kpos_q  <= 4'd0;
			enc_q   <= '0;
			dec_q   <= 8'd0;
			pbyte_q <= 8'd0;
			pcnt_q  <= 2'd0;
			found_q <= 1'b0;
		end else if (take) begin
			if (end_of_body) begin
				phase_q <= PH_MATCH;
				kpos_q  <= 4'd0;
				enc_q   <= '0;
				dec_q   <= 8'd0;
				pbyte_q <= 8'd0;
				pcnt_q  <= 2'd0;
				found_q <= 1'b0;
			end else begin
				phase_q <= ph;
				kpos_q  <= kp;
				enc_q   <= ec;
				dec_q   <= dec_nxt;
				pbyte_q <= px;
				pcnt_q  <= pc;
				found_q <= fnd;
			end
		end
	end

endmodule

/* src/ffud_res_fifo.sv */
// ----------------------------------------------------------------------------
// ffud_res_fifo
// Result queue: takes up to four results per cycle, hands out one when m_tready.
// ----------------------------------------------------------------------------
module ffud_res_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ffud_pkg::res_batch_t batch,
	output logic                 space,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output ffud_pkg::result_t    head
);
	import ffud_pkg::*;

	result_t           mem_q [RES_DEPTH];
	logic [RES_AW-1:0] wr_ptr_q;
	logic [RES_AW-1:0] rd_ptr_q;
	logic [RES_CW-1:0] cnt_q;
	logic [2:0]        n_wr;
	logic              pop;

	assign n_wr     = push ? batch.count : 3'd0;
	assign m_tvalid = (cnt_q != '0);
	assign pop      = m_tvalid && m_tready;
	assign head     = mem_q[rd_ptr_q];
	// room for a full batch regardless of the drain side
	assign space    = (cnt_q <= RES_CW'(RES_DEPTH - RES_MAX));

	always_ff @(posedge clk) begin
		for (int i = 0; i < RES_MAX; i++) begin
			if (push && 3'(i) < batch.count)
				mem_q[wr_ptr_q + RES_AW'(i)] <= batch.item[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RES_AW'(n_wr);
			if (pop)
				rd_ptr_q <= rd_ptr_q + RES_AW'(1);
			cnt_q <= cnt_q + RES_CW'(n_wr) - RES_CW'(pop);
		end
	end

endmodule

/* src/form_field_extract_url_decode.sv */
// ----------------------------------------------------------------------------
// form_field_extract_url_decode
// Extracts and percent-decodes one field of an urlencoded form body.
// ----------------------------------------------------------------------------
// Body bytes enter on the s_ stream, one per request, and each is matched and
// decoded in the cycle it is accepted; its results (decoded bytes, and a closing
// result with tlast when end_of_body is set) go into an 8-entry result queue
// that drains one result per cycle on the m_ stream while m_tready is high.
// Plain value bytes and key/skip bytes yield at most one result each and stream
// at one per clock while the queue has room. A byte can yield up to four results
// (broken escape at the value cap plus close); input is held off while more than
// four results sit in the queue. No clearing pass after reset. Users must write
// registers through the cfg_ port only while idle; the block never checks it.
module form_field_extract_url_decode #(
	parameter int unsigned MAX_ENCODED_LEN = ffud_pkg::MAX_ENCODED_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] body_byte
	input  logic        s_tlast,   // end_of_body
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic [1:0]  m_tuser,   // [0] byte_valid, [1] found
	output logic        m_tlast,   // closing result
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import ffud_pkg::*;

	cfg_t       cfg;
	res_batch_t batch;
	result_t    head;
	logic       space;
	logic       take;

	assign s_tready = space;
	assign take     = s_tvalid && s_tready;

	ffud_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ffud_parser #(
		.MAX_ENCODED_LEN (MAX_ENCODED_LEN)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.body_byte   (s_tdata),
		.end_of_body (s_tlast),
		.cfg         (cfg),
		.batch       (batch)
	);

	ffud_res_fifo u_res_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (take),
		.batch    (batch),
		.space    (space),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.head     (head)
	);

	assign m_tdata = head.out_byte;
	assign m_tuser = {head.found, head.byte_valid};
	assign m_tlast = head.last;

endmodule
